### sv/pmsv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmsv_pkg
// Types, codes and constants shared by the peer message stream validator.
// ----------------------------------------------------------------------------
package pmsv_pkg;

    localparam logic [31:0] MAGIC_WORD    = 32'h534C5032;
    localparam logic [31:0] WIRE_VERSION  = 32'd1;
    localparam int          MANDATORY_BIT = 31;
    localparam logic [32:0] SEEN_MAX      = 33'h1FFFFFFFF;

    localparam logic [31:0] MAX_MESSAGE_BYTES_RESET  = 32'd65536;
    localparam logic [15:0] MAX_ENDPOINT_COUNT_RESET = 16'd64;
    localparam logic [31:0] VALID_KIND_MASK_RESET    = 32'd63;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_MESSAGE_BYTES  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_ENDPOINT_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_VALID_KIND_MASK    = 2'd2;

    typedef enum logic [4:0] {
        PH_MAGIC       = 5'd0,
        PH_VERSION     = 5'd1,
        PH_KIND        = 5'd2,
        PH_FLAGS       = 5'd3,
        PH_REQUEST_ID  = 5'd4,
        PH_PEER_LEN    = 5'd5,
        PH_PEER        = 5'd6,
        PH_PROTO_LEN   = 5'd7,
        PH_PROTO       = 5'd8,
        PH_CAPS        = 5'd9,
        PH_MAX_FRAME   = 5'd10,
        PH_REASON_LEN  = 5'd11,
        PH_REASON      = 5'd12,
        PH_EP_COUNT    = 5'd13,
        PH_REC_PEER_LEN = 5'd14,
        PH_REC_PEER    = 5'd15,
        PH_REC_HOST_LEN = 5'd16,
        PH_REC_HOST    = 5'd17,
        PH_REC_PORT    = 5'd18,
        PH_REC_CAPS    = 5'd19,
        PH_PAYLOAD_LEN = 5'd20,
        PH_PAYLOAD     = 5'd21,
        PH_IDLE        = 5'd22
    } phase_t;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_OVERSIZE  = 4'd1,
        ST_MAGIC     = 4'd2,
        ST_VERSION   = 4'd3,
        ST_KIND      = 4'd4,
        ST_MANDATORY = 4'd5,
        ST_ENDPOINTS = 4'd6,
        ST_TRUNCATED = 4'd7,
        ST_TRAILING  = 4'd8
    } status_t;

    typedef struct packed {
        logic [4:0]  field_tag;
        logic [7:0]  out_byte;
        logic [15:0] record_index;
        logic        field_end;
        logic        frame_done;
        logic [3:0]  status;
    } result_t;

    function automatic logic [3:0] fixed_size(input phase_t p);
        logic [3:0] s;
        unique case (p)
            PH_MAGIC, PH_FLAGS, PH_PEER_LEN, PH_PROTO_LEN, PH_REASON_LEN,
            PH_EP_COUNT, PH_REC_PEER_LEN, PH_REC_HOST_LEN,
            PH_PAYLOAD_LEN:                         s = 4'd4;
            PH_VERSION, PH_KIND, PH_REC_PORT:       s = 4'd2;
            PH_REQUEST_ID, PH_CAPS, PH_MAX_FRAME,
            PH_REC_CAPS:                            s = 4'd8;
            default:                                s = 4'd0;
        endcase
        return s;
    endfunction

    function automatic logic is_data_phase(input phase_t p);
        return p == PH_PEER || p == PH_PROTO || p == PH_REASON || p == PH_REC_PEER
            || p == PH_REC_HOST || p == PH_PAYLOAD;
    endfunction

endpackage

### sv/pmsv_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmsv_cfg
// Configuration registers of the validator, written through a plain port.
// ----------------------------------------------------------------------------
module pmsv_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [pmsv_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pmsv_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic [31:0]                        max_message_bytes,
    output logic [15:0]                        max_endpoint_count,
    output logic [31:0]                        valid_kind_mask
);

    logic [31:0] max_msg_reg;
    logic [15:0] max_ep_reg;
    logic [31:0] kind_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_msg_reg   <= pmsv_pkg::MAX_MESSAGE_BYTES_RESET;
            max_ep_reg    <= pmsv_pkg::MAX_ENDPOINT_COUNT_RESET;
            kind_mask_reg <= pmsv_pkg::VALID_KIND_MASK_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == pmsv_pkg::REG_MAX_MESSAGE_BYTES)
                max_msg_reg <= cfg_data;
            if (cfg_index == pmsv_pkg::REG_MAX_ENDPOINT_COUNT)
                max_ep_reg <= cfg_data[15:0];
            if (cfg_index == pmsv_pkg::REG_VALID_KIND_MASK)
                kind_mask_reg <= cfg_data;
        end
    end

    assign max_message_bytes  = max_msg_reg;
    assign max_endpoint_count = max_ep_reg;
    assign valid_kind_mask    = kind_mask_reg;

endmodule

### sv/pmsv_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmsv_parser
// Per-frame parse state and the combinational update that tags one byte.
// ----------------------------------------------------------------------------
module pmsv_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          in_byte,
    input  logic                frame_end,
    input  logic [31:0]         max_message_bytes,
    input  logic [15:0]         max_endpoint_count,
    input  logic [31:0]         valid_kind_mask,
    output pmsv_pkg::result_t   result
);

    pmsv_pkg::phase_t phase_reg, phase_next;
    logic [31:0] bif_reg, bif_next;
    logic [31:0] accum_reg, accum_next;
    logic [31:0] flen_reg, flen_next;
    logic [31:0] rtot_reg, rtot_next;
    logic [15:0] rdone_reg, rdone_next;
    logic [32:0] seen_reg, seen_next;
    logic [3:0]  ferr_reg, ferr_next;

    logic [31:0] acc_new;
    logic [31:0] v;
    logic        done;
    logic [15:0] rinc;

    always_comb
    begin
        phase_next = phase_reg;
        bif_next   = bif_reg;
        accum_next = accum_reg;
        flen_next  = flen_reg;
        rtot_next  = rtot_reg;
        rdone_next = rdone_reg;
        ferr_next  = ferr_reg;
        seen_next  = (seen_reg < pmsv_pkg::SEEN_MAX) ? seen_reg + 33'd1 : seen_reg;
        acc_new    = {accum_reg[23:0], in_byte};
        v          = acc_new;
        done       = 1'b0;
        rinc       = rdone_reg + 16'd1;

        result.field_tag    = pmsv_pkg::PH_IDLE;
        result.out_byte     = in_byte;
        result.record_index = '0;
        result.field_end    = 1'b0;
        result.frame_done   = frame_end;
        result.status       = pmsv_pkg::ST_OK;

        if (phase_reg == pmsv_pkg::PH_IDLE)
        begin
            if (ferr_reg == pmsv_pkg::ST_OK)
                ferr_next = pmsv_pkg::ST_TRAILING;
        end
        else
        begin
            result.field_tag = phase_reg;
            if (phase_reg >= pmsv_pkg::PH_REC_PEER_LEN && phase_reg <= pmsv_pkg::PH_REC_CAPS)
                result.record_index = rdone_reg;
            if (pmsv_pkg::is_data_phase(phase_reg))
            begin
                done = ({1'b0, bif_reg} + 33'd1) >= {1'b0, flen_reg};
                v    = accum_reg;
            end
            else
            begin
                accum_next = acc_new;
                done = ({1'b0, bif_reg} + 33'd1) >= {29'd0, pmsv_pkg::fixed_size(phase_reg)};
            end
            bif_next = bif_reg + 32'd1;
            if (done)
            begin
                result.field_end = 1'b1;
                bif_next   = '0;
                accum_next = '0;
                unique case (phase_reg)
                    pmsv_pkg::PH_MAGIC:
                        if (v != pmsv_pkg::MAGIC_WORD)
                        begin
                            ferr_next = pmsv_pkg::ST_MAGIC;
                            phase_next = pmsv_pkg::PH_IDLE;
                        end
                        else phase_next = pmsv_pkg::PH_VERSION;
                    pmsv_pkg::PH_VERSION:
                        if (v != pmsv_pkg::WIRE_VERSION)
                        begin
                            ferr_next = pmsv_pkg::ST_VERSION;
                            phase_next = pmsv_pkg::PH_IDLE;
                        end
                        else phase_next = pmsv_pkg::PH_KIND;
                    pmsv_pkg::PH_KIND:
                        if (v[31:5] != '0 || !valid_kind_mask[v[4:0]])
                        begin
                            ferr_next = pmsv_pkg::ST_KIND;
                            phase_next = pmsv_pkg::PH_IDLE;
                        end
                        else phase_next = pmsv_pkg::PH_FLAGS;
                    pmsv_pkg::PH_FLAGS:
                        if (v[pmsv_pkg::MANDATORY_BIT])
                        begin
                            ferr_next = pmsv_pkg::ST_MANDATORY;
                            phase_next = pmsv_pkg::PH_IDLE;
                        end
                        else phase_next = pmsv_pkg::PH_REQUEST_ID;
                    pmsv_pkg::PH_REQUEST_ID: phase_next = pmsv_pkg::PH_PEER_LEN;
                    pmsv_pkg::PH_PEER_LEN:
                    begin
                        flen_next = v;
                        phase_next = (v == '0) ? pmsv_pkg::PH_PROTO_LEN : pmsv_pkg::PH_PEER;
                    end
                    pmsv_pkg::PH_PEER: phase_next = pmsv_pkg::PH_PROTO_LEN;
                    pmsv_pkg::PH_PROTO_LEN:
                    begin
                        flen_next = v;
                        phase_next = (v == '0) ? pmsv_pkg::PH_CAPS : pmsv_pkg::PH_PROTO;
                    end
                    pmsv_pkg::PH_PROTO: phase_next = pmsv_pkg::PH_CAPS;
                    pmsv_pkg::PH_CAPS: phase_next = pmsv_pkg::PH_MAX_FRAME;
                    pmsv_pkg::PH_MAX_FRAME: phase_next = pmsv_pkg::PH_REASON_LEN;
                    pmsv_pkg::PH_REASON_LEN:
                    begin
                        flen_next = v;
                        phase_next = (v == '0) ? pmsv_pkg::PH_EP_COUNT : pmsv_pkg::PH_REASON;
                    end
                    pmsv_pkg::PH_REASON: phase_next = pmsv_pkg::PH_EP_COUNT;
                    pmsv_pkg::PH_EP_COUNT:
                    begin
                        rtot_next  = v;
                        rdone_next = '0;
                        if (v > {16'd0, max_endpoint_count})
                        begin
                            ferr_next = pmsv_pkg::ST_ENDPOINTS;
                            phase_next = pmsv_pkg::PH_IDLE;
                        end
                        else
                            phase_next = (v == '0) ? pmsv_pkg::PH_PAYLOAD_LEN
                                                   : pmsv_pkg::PH_REC_PEER_LEN;
                    end
                    pmsv_pkg::PH_REC_PEER_LEN:
                    begin
                        flen_next = v;
                        phase_next = (v == '0) ? pmsv_pkg::PH_REC_HOST_LEN
                                               : pmsv_pkg::PH_REC_PEER;
                    end
                    pmsv_pkg::PH_REC_PEER: phase_next = pmsv_pkg::PH_REC_HOST_LEN;
                    pmsv_pkg::PH_REC_HOST_LEN:
                    begin
                        flen_next = v;
                        phase_next = (v == '0) ? pmsv_pkg::PH_REC_PORT : pmsv_pkg::PH_REC_HOST;
                    end
                    pmsv_pkg::PH_REC_HOST: phase_next = pmsv_pkg::PH_REC_PORT;
                    pmsv_pkg::PH_REC_PORT: phase_next = pmsv_pkg::PH_REC_CAPS;
                    pmsv_pkg::PH_REC_CAPS:
                    begin
                        rdone_next = rinc;
                        phase_next = ({16'd0, rinc} >= rtot_reg) ? pmsv_pkg::PH_PAYLOAD_LEN
                                                                 : pmsv_pkg::PH_REC_PEER_LEN;
                    end
                    pmsv_pkg::PH_PAYLOAD_LEN:
                    begin
                        flen_next = v;
                        phase_next = (v == '0) ? pmsv_pkg::PH_IDLE : pmsv_pkg::PH_PAYLOAD;
                    end
                    default: phase_next = pmsv_pkg::PH_IDLE;
                endcase
            end
        end

        if (frame_end)
        begin
            if (seen_next > {1'b0, max_message_bytes})
                result.status = pmsv_pkg::ST_OVERSIZE;
            else if (ferr_next != pmsv_pkg::ST_OK)
                result.status = ferr_next;
            else if (phase_next != pmsv_pkg::PH_IDLE)
                result.status = pmsv_pkg::ST_TRUNCATED;
            else
                result.status = pmsv_pkg::ST_OK;
            phase_next = pmsv_pkg::PH_MAGIC;
            bif_next   = '0;
            accum_next = '0;
            flen_next  = '0;
            rtot_next  = '0;
            rdone_next = '0;
            seen_next  = '0;
            ferr_next  = pmsv_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= pmsv_pkg::PH_MAGIC;
            bif_reg   <= '0;
            accum_reg <= '0;
            flen_reg  <= '0;
            rtot_reg  <= '0;
            rdone_reg <= '0;
            seen_reg  <= '0;
            ferr_reg  <= pmsv_pkg::ST_OK;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            bif_reg   <= bif_next;
            accum_reg <= accum_next;
            flen_reg  <= flen_next;
            rtot_reg  <= rtot_next;
            rdone_reg <= rdone_next;
            seen_reg  <= seen_next;
            ferr_reg  <= ferr_next;
        end
    end

endmodule

### sv/peer_message_stream_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peer_message_stream_validator
// Tags each byte of a framed peer message and reports the frame status.
// ----------------------------------------------------------------------------
// Bytes enter on the s_axis channel, one transfer per byte, with s_axis_tlast
// on the final byte of a frame. Each byte leaves on m_axis as one transfer
// carrying its field tag, the byte, the endpoint record index and the field
// end flag; m_axis_tlast copies the frame mark and, on that transfer, the
// status in tuser is valid.
// An input transfer is parsed in the cycle it is taken and its result stands
// in the output register on the next cycle, one byte per cycle while the
// receiver takes each result. The parse state updates as each byte is taken,
// so the rate is set only by the output register draining.
// When the receiver stalls, the output register holds its result and the
// input is still taken while the register is empty or being read that cycle.
// Reset returns the parser to the start of a frame and loads the register
// defaults. Registers are written through cfg_we, cfg_index and cfg_data.
// ----------------------------------------------------------------------------
module peer_message_stream_validator
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // in_byte
    input  logic                              s_axis_tlast,  // frame_end
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [31:0]                       m_axis_tdata,  // out_byte, record_index, 8 zeros
    output logic [9:0]                        m_axis_tuser,  // field_tag, field_end, status
    output logic                              m_axis_tlast,  // frame_done
    input  logic                              cfg_we,
    input  logic [pmsv_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pmsv_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [31:0] max_message_bytes;
    logic [15:0] max_endpoint_count;
    logic [31:0] valid_kind_mask;
    logic        step;
    logic        out_valid_reg;
    pmsv_pkg::result_t res;
    pmsv_pkg::result_t out_reg;

    pmsv_cfg u_cfg
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .max_message_bytes  (max_message_bytes),
        .max_endpoint_count (max_endpoint_count),
        .valid_kind_mask    (valid_kind_mask)
    );

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign step = s_axis_tvalid && s_axis_tready;

    pmsv_parser u_parser
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .step               (step),
        .in_byte            (s_axis_tdata),
        .frame_end          (s_axis_tlast),
        .max_message_bytes  (max_message_bytes),
        .max_endpoint_count (max_endpoint_count),
        .valid_kind_mask    (valid_kind_mask),
        .result             (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s_axis_tready)
            out_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {8'd0, out_reg.record_index, out_reg.out_byte};
    assign m_axis_tuser  = {out_reg.status, out_reg.field_end, out_reg.field_tag};
    assign m_axis_tlast  = out_reg.frame_done;

endmodule
